[rtl/unpremultiply_srgb_encode_pixel_core_defines.svh]
// Assertion macros for the pixel encode core.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef UNPREMULTIPLY_SRGB_ENCODE_PIXEL_CORE_DEFINES_SVH
`define UNPREMULTIPLY_SRGB_ENCODE_PIXEL_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define USP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a cause implies an effect in the next cycle
`define USP_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error(msg);

`endif

[rtl/usp_pkg.sv]
// Shared types, constants and tables for the pixel encode core.
// No dependencies.
package usp_pkg;

  // Ratio precision of the unpremultiply divide
  localparam int unsigned RatioBits = 12;
  localparam int unsigned FullScale = (1 << RatioBits) - 1;
  // Pipeline depth of one color lane: load, one stage per quotient bit, eight search stages
  localparam int unsigned LaneLat = RatioBits + 9;
  localparam int unsigned AddrLat = 2;

  localparam logic [7:0] GrayCode = 8'd187;
  localparam logic [7:0] Opaque   = 8'd255;

  // Last ratio on the linear segment of the curve
  localparam longint unsigned LinLast = (64'd31308 * FullScale) / 64'd10000000;
  localparam longint unsigned LinDen  = 64'd10 * FullScale;

  typedef logic [RatioBits-1:0] ratio_t;
  typedef ratio_t thr_tab_t [256];

  typedef struct packed {
    logic [23:0] addr;
    logic        oof;
  } side_t;

  // Smallest ratio whose encoded value reaches code k on the power segment
  function automatic thr_tab_t build_thr();
    thr_tab_t   tab;
    real        base;
    real        t;
    longint     n;
    for (int k = 0; k < 256; k++) begin
      base = (real'(k) / 255.0 + 0.055) / 1.055;
      t    = real'(FullScale) * (base ** 2.4);
      n    = longint'($rtoi(t));
      if (real'(n) < t) n = n + 1;
      if (k == 255 || n > longint'(FullScale)) n = longint'(FullScale);
      tab[k] = ratio_t'(n);
    end
    return tab;
  endfunction

  localparam thr_tab_t ThrTab = build_thr();

  // Code on the linear segment, ratio at most LinLast
  function automatic logic [7:0] lin_code(ratio_t q);
    longint unsigned c;
    c = (64'd32946 * longint'(q)) / LinDen;
    return (c > 64'd255) ? 8'd255 : c[7:0];
  endfunction

endpackage

[rtl/usp_lane.sv]
// One color lane: clamp, pipelined restoring divide, pipelined threshold search.
// Depends on usp_pkg.
module usp_lane (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [31:0] sum_i,
  input  logic [31:0] weight_i,
  output logic [7:0]  code_o
);

  localparam int unsigned Rb = usp_pkg::RatioBits;

  logic [31:0]  dr_q [Rb+1];
  logic [31:0]  wt_q [Rb+1];
  logic [Rb-1:0] dq_q [Rb+1];
  logic         full_q [Rb+1];
  logic         zero_q [Rb+1];

  logic [Rb-1:0] sq_q [8];
  logic [7:0]    sc_q [8];
  logic          sz_q [8];

  logic [31:0] x;
  assign x = (sum_i < weight_i) ? sum_i : weight_i;

  // Load: clamp the sum to the weight
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_q[0]   <= x;
      wt_q[0]   <= weight_i;
      dq_q[0]   <= '0;
      full_q[0] <= (x >= weight_i);
      zero_q[0] <= (weight_i == 32'd0);
    end
  end

  // Divide: one quotient bit per stage, remainder stays at or below the weight
  for (genvar i = 1; i <= Rb; i++) begin : g_div
    logic [32:0] t;
    logic        ge;
    assign t  = {dr_q[i-1], 1'b0};
    assign ge = (t >= {1'b0, wt_q[i-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[i]   <= ge ? 32'(t - {1'b0, wt_q[i-1]}) : t[31:0];
        wt_q[i]   <= wt_q[i-1];
        dq_q[i]   <= {dq_q[i-1][Rb-2:0], ge};
        full_q[i] <= full_q[i-1];
        zero_q[i] <= zero_q[i-1];
      end
    end
  end

  // Search: set one code bit per stage, MSB first, against the threshold table
  for (genvar j = 0; j < 8; j++) begin : g_srch
    logic [Rb-1:0] q_in;
    logic [7:0]    c_in;
    logic          z_in;
    logic [7:0]    cand;
    if (j == 0) begin : g_first
      assign q_in = full_q[Rb] ? Rb'(usp_pkg::FullScale) : dq_q[Rb];
      assign c_in = 8'd0;
      assign z_in = zero_q[Rb];
    end else begin : g_rest
      assign q_in = sq_q[j-1];
      assign c_in = sc_q[j-1];
      assign z_in = sz_q[j-1];
    end
    assign cand = c_in | (8'd1 << (7 - j));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[j] <= q_in;
        sc_q[j] <= (q_in >= usp_pkg::ThrTab[cand]) ? cand : c_in;
        sz_q[j] <= z_in;
      end
    end
  end

  // Pick gray, linear segment or power segment code
  always_comb begin
    if (sz_q[7]) begin
      code_o = usp_pkg::GrayCode;
    end else if (32'(sq_q[7]) <= 32'(usp_pkg::LinLast)) begin
      code_o = usp_pkg::lin_code(sq_q[7]);
    end else begin
      code_o = sc_q[7];
    end
  end

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

[rtl/usp_addr.sv]
// Flipped write address and frame check, two register stages.
// Depends on usp_pkg.
module usp_addr (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [11:0]   column_i,
  input  logic [11:0]   row_i,
  input  logic [12:0]   width_i,
  input  logic [12:0]   height_i,
  output usp_pkg::side_t side_o
);

  logic        oof_q;
  logic [12:0] diff_q;
  logic [12:0] w_q;
  logic [11:0] col_q;
  logic [25:0] sum;

  // Check bounds and flip the row
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oof_q  <= ({1'b0, column_i} >= width_i) || ({1'b0, row_i} >= height_i);
      diff_q <= 13'(height_i - 13'd1 - {1'b0, row_i});
      w_q    <= width_i;
      col_q  <= column_i;
    end
  end

  assign sum = ({13'd0, diff_q} * {13'd0, w_q}) + {14'd0, col_q};

  // Form the linear index, zero when outside the frame
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o.oof  <= oof_q;
      side_o.addr <= oof_q ? 24'd0 : sum[23:0];
    end
  end

endmodule

[rtl/unpremultiply_srgb_encode_pixel_core.sv]
// Top level of the pixel encode core: three color lanes, address unit, output merge.
// Depends on usp_pkg, usp_lane, usp_addr and the defines header.
//
//  channel  | signals                                   | word
//  ---------+-------------------------------------------+---------------------------------
//  in       | s_axis_tvalid/tready/tdata[151:0]         | red, green, blue, weight, col, row
//  out      | m_axis_tvalid/tready/tdata[63:0]          | codes, opacity, address, flag
//  config   | cfg_valid_i/cfg_ready_o/cfg_index_i/data  | 0 width, 1 height
//
// One word per cycle unless the output stalls; each word passes the load stage, the
// one-bit-per-stage divide and eight-stage code search of each lane, then the output register.
// Reset clears valids and sets both dimensions to 1024.
// A stalled output register freezes the whole pipeline; input ready follows it.
`include "unpremultiply_srgb_encode_pixel_core_defines.svh"

module unpremultiply_srgb_encode_pixel_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // red_sum[31:0], green_sum[63:32], blue_sum[95:64], weight[127:96],
  // column[139:128], row[151:140]
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // red_code[7:0], green_code[15:8], blue_code[23:16], opacity[31:24],
  // pixel_address[55:32], out_of_frame[56], zero fill[63:57]
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [12:0]  cfg_data_i
);

  localparam int unsigned Lat    = usp_pkg::LaneLat;
  localparam int unsigned DimCap = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam int unsigned SideN  = Lat - usp_pkg::AddrLat;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;

  logic [12:0] width_q, height_q;
  logic [12:0] w_eff, h_eff;
  logic        en;
  logic [Lat-1:0] vld_q;
  logic [7:0]  code [3];
  usp_pkg::side_t side_a;
  usp_pkg::side_t side_q [SideN];
  logic        m_vld_q;
  logic [63:0] m_data_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd1024;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegWidth)  width_q  <= cfg_data_i;
      if (cfg_index_i == RegHeight) height_q <= cfg_data_i;
    end
  end

  assign w_eff = (32'(width_q)  > DimCap) ? 13'(DimCap) : width_q;
  assign h_eff = (32'(height_q) > DimCap) ? 13'(DimCap) : height_q;

  // Advance whenever the output register is free or being drained
  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Color lanes
  for (genvar c = 0; c < 3; c++) begin : g_lane
    usp_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .sum_i    (s_axis_tdata[32*c +: 32]),
      .weight_i (s_axis_tdata[127:96]),
      .code_o   (code[c])
    );
  end

  usp_addr u_addr (
    .clk_i    (clk_i),
    .en_i     (en),
    .column_i (s_axis_tdata[139:128]),
    .row_i    (s_axis_tdata[151:140]),
    .width_i  (w_eff),
    .height_i (h_eff),
    .side_o   (side_a)
  );

  // Delay address results to line up with the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_a;
      for (int i = 1; i < SideN; i++) side_q[i] <= side_q[i-1];
    end
  end

  // Merge lanes into the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= {7'd0, side_q[SideN-1].oof, side_q[SideN-1].addr,
                   usp_pkg::Opaque, code[2], code[1], code[0]};
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

  `USP_ASSERT(a_oof_addr, !(m_axis_tvalid && m_axis_tdata[56]) || m_axis_tdata[55:32] == 24'd0, "out-of-frame word with nonzero address")
  `USP_ASSERT(a_opaque, !m_axis_tvalid || m_axis_tdata[31:24] == usp_pkg::Opaque, "opacity not 255")
  `USP_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted word not in pipeline")

endmodule

[tb/unpremultiply_srgb_encode_pixel_core_checker.sv]
// Checker for the pixel encode core: watches the input, output and config channels.
// Predicts each output word and compares it field by field. Depends on nothing but ports.
module unpremultiply_srgb_encode_pixel_core_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [12:0]  cfg_data_i,
  output int           pending_o,
  output int           errors_o
);

  localparam int unsigned Full = 4095;
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;

  typedef struct packed {
    logic        oof;
    logic [23:0] addr;
    logic [7:0]  opacity;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_out_t;

  logic [7:0] srgb_lut [4096];
  logic [12:0] width_q, height_q;
  pixel_out_t expected_px [$];

  // Exact power-segment test: E(q/Full) >= k/255
  function automatic bit code_reached(int unsigned q, int unsigned k);
    bit [383:0] lhs, rhs;
    lhs = 384'd1;
    rhs = 384'd1;
    for (int i = 0; i < 5; i++) begin
      lhs = lhs * 384'(q);
      rhs = rhs * 384'(Full);
    end
    for (int i = 0; i < 12; i++) begin
      lhs = lhs * 384'd269025;
      rhs = rhs * 384'(1000 * k + 14025);
    end
    return lhs >= rhs;
  endfunction

  function automatic logic [7:0] srgb_code(int unsigned q);
    int unsigned lo, hi, mid;
    longint unsigned c;
    if (64'(q) * 64'd10000000 <= 64'd31308 * Full) begin
      c = (64'd32946 * q) / (64'd10 * Full);
      return (c > 255) ? 8'd255 : c[7:0];
    end
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (code_reached(q, mid)) lo = mid;
      else hi = mid - 1;
    end
    return lo[7:0];
  endfunction

  function automatic logic [7:0] channel_code(logic [31:0] sum, logic [31:0] wt);
    longint unsigned x, q;
    if (wt == 0) return 8'd187;
    x = (sum < wt) ? sum : wt;
    q = (x << 12) / wt;
    if (q > Full) q = Full;
    return srgb_lut[q];
  endfunction

  function automatic pixel_out_t predict_pixel(logic [151:0] d);
    pixel_out_t p;
    int unsigned w, h, col, row;
    longint unsigned idx;
    w   = (width_q > 4096) ? 4096 : width_q;
    h   = (height_q > 4096) ? 4096 : height_q;
    col = d[139:128];
    row = d[151:140];
    p.red     = channel_code(d[31:0], d[127:96]);
    p.green   = channel_code(d[63:32], d[127:96]);
    p.blue    = channel_code(d[95:64], d[127:96]);
    p.opacity = 8'd255;
    if (col >= w || row >= h) begin
      p.addr = '0;
      p.oof  = 1'b1;
    end else begin
      idx    = longint'(h - 1 - row) * w + col;
      p.addr = idx[23:0];
      p.oof  = 1'b0;
    end
    return p;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      errors_o++;
    end
  endtask

  // Fill the code table once up front
  initial begin
    for (int q = 0; q < 4096; q++) srgb_lut[q] = srgb_code(q);
  end

  // Track config, queue predictions, compare delivered words
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t exp_px, got_px;
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd1024;
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegWidth) width_q <= cfg_data_i;
        else if (cfg_index_i == RegHeight) height_q <= cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_px = m_axis_tdata[56:0];
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0h", $time, got_px);
          errors_o++;
        end else begin
          exp_px = expected_px.pop_front();
          check_field("red_code", exp_px.red, got_px.red);
          check_field("green_code", exp_px.green, got_px.green);
          check_field("blue_code", exp_px.blue, got_px.blue);
          check_field("opacity", exp_px.opacity, got_px.opacity);
          check_field("pixel_address", exp_px.addr, got_px.addr);
          check_field("out_of_frame", exp_px.oof, got_px.oof);
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_px.push_back(predict_pixel(s_axis_tdata));
      pending_o = expected_px.size();
    end
  end

endmodule

[tb/tb.sv]
// Top of the pixel encode core testbench: clock, reset, stimulus and verdict.
// Depends on the core RTL and unpremultiply_srgb_encode_pixel_core_checker.
module tb;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [151:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic         cfg_valid_i, cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [12:0]  cfg_data_i;
  int           pending, errors;
  int           send_idle, recv_idle;
  bit           press_req, press_done;
  int unsigned  cur_w, cur_h;

  unpremultiply_srgb_encode_pixel_core u_top (.*);

  unpremultiply_srgb_encode_pixel_core_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Receiver: random stalls, plus one long hold-off to back up the pipeline
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (press_req && !press_done) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        press_done = 1'b1;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                           logic [31:0] wt, logic [11:0] col, logic [11:0] row);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col, wt, b, g, r};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Write one register; call only while drained
  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegWidth) cur_w = (val > 4096) ? 4096 : val;
    else cur_h = (val > 4096) ? 4096 : val;
  endtask

  task automatic send_random();
    logic [31:0] wt, s [3];
    logic [11:0] col, row;
    case ($urandom_range(9))
      0:       wt = 32'd0;
      1, 2:    wt = $urandom_range(1, 5000);
      default: wt = $urandom;
    endcase
    foreach (s[i]) s[i] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(wt, 0);
    if ($urandom_range(3) != 0 && cur_w > 0 && cur_h > 0) begin
      col = 12'($urandom_range(cur_w - 1));
      row = 12'($urandom_range(cur_h - 1));
    end else begin
      col = 12'($urandom);
      row = 12'($urandom);
    end
    send_word(s[0], s[1], s[2], wt, col, row);
  endtask

  initial begin
    int unsigned widths [6]  = '{4096, 1, 8191, 0, 640, 1024};
    int unsigned heights [6] = '{4096, 1, 8191, 0, 480, 333};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegWidth;
    cfg_data_i    = '0;
    send_idle     = 0;
    recv_idle     = 0;
    press_req     = 1'b0;
    press_done    = 1'b0;
    cur_w         = 1024;
    cur_h         = 1024;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small frame, extremes and special cases
    write_reg(RegWidth, 13'd16);
    write_reg(RegHeight, 13'd8);
    send_word(32'd5, 32'd9, 32'd0, 32'd0, 12'd0, 12'd0);             // zero weight
    send_word('1, '1, '1, '1, 12'd15, 12'd7);                        // full scale
    send_word(32'd0, 32'd1, '1, '1, 12'd4095, 12'd4095);             // tiny ratio, out of frame
    send_word('1, 32'd7, 32'd100, 32'd50, 12'd16, 12'd0);            // sum above weight
    send_word(32'd1, 32'd1, 32'd0, 32'd1, 12'd0, 12'd8);             // unit weight
    for (int q = 1; q <= 14; q++)                                    // linear/power knee
      send_word(32'(q), 32'(q + 1), 32'(4095 - q), 32'd4096, 12'(q), 12'(q % 8));
    send_word(32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 12'd3, 12'd5);
    send_word(32'h0001_0000, 32'h0000_8000, 32'h0000_0001, 32'h0001_0000, 12'd0, 12'd7);
    drain();

    // Random phases across frame settings and idle patterns
    for (int p = 0; p < 6; p++) begin
      write_reg(RegWidth, 13'(widths[p]));
      write_reg(RegHeight, 13'(heights[p]));
      case (p / 2)
        0: begin send_idle = 9;  recv_idle = 45; end
        1: begin send_idle = 45; recv_idle = 9;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (p == 0) press_req = 1'b1;
      for (int i = 0; i < 280; i++) send_random();
      drain();
    end

    if (errors == 0) $display("unpremultiply_srgb_encode_pixel_core verification clean");
    else $display("unpremultiply_srgb_encode_pixel_core verification failed");
    $finish;
  end

  // Run limit
  initial begin
    #(20 * 200000);
    $display("unpremultiply_srgb_encode_pixel_core verification failed");
    $finish;
  end

endmodule
